// ===== rtl/ssrc_pkg.sv =====
// Shared types and constants for the sinc resampler.
// Used by every module in rtl/.
package ssrc_pkg;

	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned STEP_W      = 20;
	localparam int unsigned SEEN_W      = 32;
	localparam int unsigned COEF_W      = 17;
	localparam int unsigned CNT_W       = 6;
	localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(32);
	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(16384);
	localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(524288);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
	localparam logic [SEEN_W:0] SEEN_LIMIT   = {1'b0, 32'hFFFF0000};
	localparam longint unsigned PI_Q30       = 64'd3373259426;

	// register indexes
	localparam logic REG_PHASE_STEP  = 1'b0;
	localparam logic REG_STEREO_MODE = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	typedef struct packed {
		sample_t mono;
		logic    last;
	} ssrc_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ssrc_qstat_t;

endpackage

// ===== rtl/ssrc_front.sv =====
// Front end: takes input frames, folds stereo to mono (or passes the left sample when stereo mode is off)
// and hands jobs to the queue. Depends on ssrc_pkg.
module ssrc_front (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ssrc_pkg::sample_t    left_sample,
	input  ssrc_pkg::sample_t    right_sample,
	input  logic                 final_frame,
	input  logic                 stereo_mode,
	input  ssrc_pkg::ssrc_qstat_t q_stat,
	output logic                 push,
	output ssrc_pkg::ssrc_job_t  job
);
	import ssrc_pkg::*;

	logic signed [SAMPLE_W:0] sum;
	logic signed [SAMPLE_W:0] sum_adj;

	// average toward zero: bias negative sums by one before the shift
	assign sum      = (SAMPLE_W+1)'(left_sample) + (SAMPLE_W+1)'(right_sample);
	assign sum_adj  = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
	assign job.mono = stereo_mode ? sample_t'(sum_adj >>> 1) : left_sample;
	assign job.last = final_frame;
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

endmodule

// ===== rtl/ssrc_queue.sv =====
// Two-entry request queue between front and back end.
// Depends on ssrc_pkg.
module ssrc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ssrc_pkg::ssrc_job_t   push_job,
	input  logic                  pop,
	output ssrc_pkg::ssrc_job_t   head,
	output ssrc_pkg::ssrc_qstat_t stat
);
	import ssrc_pkg::*;

	ssrc_job_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head       = slot_q[rd_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/ssrc_back.sv =====
// Back end: sample history, position tracking, tap pipeline with one shared MAC,
// coefficient ROM and the output register. Depends on ssrc_pkg.
module ssrc_back #(
	parameter int unsigned TAP_REACH           = 4,
	parameter int unsigned HISTORY_DEPTH       = 16,
	parameter int unsigned PHASE_FRAC_BITS     = 16,
	parameter int unsigned COEF_STEPS_PER_UNIT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ssrc_pkg::STEP_W-1:0]   step,
	input  ssrc_pkg::ssrc_job_t           head,
	input  ssrc_pkg::ssrc_qstat_t         q_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ssrc_pkg::sample_t             out_sample,
	output logic                          run_end,
	output logic                          sound_end
);
	import ssrc_pkg::*;

	localparam int unsigned F        = PHASE_FRAC_BITS;
	localparam int unsigned POS_W    = SEEN_W + F;
	localparam int unsigned CEN_W    = SEEN_W + 1;
	localparam int unsigned K_W      = SEEN_W + 3;
	localparam int unsigned TAPS     = 2 * TAP_REACH + 1;
	localparam int unsigned TC_W     = $clog2(TAPS);
	localparam int unsigned RA       = $clog2(HISTORY_DEPTH);
	localparam int unsigned D_W      = F + $clog2(TAP_REACH + 1);
	localparam int unsigned SW       = $clog2(COEF_STEPS_PER_UNIT + 1);
	localparam int unsigned ROM_DEPTH = (TAPS * COEF_STEPS_PER_UNIT) / 2 + 1;
	localparam int unsigned ROM_AW   = $clog2(ROM_DEPTH);
	localparam int unsigned PROD_W   = COEF_W + SAMPLE_W;
	localparam int unsigned ACC_W    = PROD_W + TC_W + 1;
	localparam logic [POS_W:0] HALF  = (POS_W+1)'(1) << (F - 1);
	localparam longint unsigned S_U  = 64'(COEF_STEPS_PER_UNIT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_TAPS  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;

	logic [2:0]        state_q;
	logic [SEEN_W-1:0] seen_q;
	logic [POS_W-1:0]  pos_q;
	logic [RA-1:0]     wr_ptr_q;
	logic [RA-1:0]     last_ptr_q;
	logic              final_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TC_W-1:0]   tap_q;
	logic signed [ACC_W-1:0] acc_q;
	sample_t           res_q;

	sample_t ring_q [HISTORY_DEPTH];
	coef_t   coef_rom [ROM_DEPTH];

	// sinc(m/S) with 15 fraction bits; sine by Taylor series to the 13th power in Q30
	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
		localparam longint unsigned M    = 64'(g);
		localparam longint unsigned R0   = M % S_U;
		localparam longint unsigned R    = (R0 * 2 > S_U) ? S_U - R0 : R0;
		localparam bit              NEG  = ((M / S_U) & 64'd1) != 64'd0;
		localparam longint unsigned TH   = (PI_Q30 * R) / S_U;
		localparam longint unsigned TH2  = (TH * TH) >> 30;
		localparam longint unsigned T1   = ((TH * TH2) >> 30) / 64'd6;
		localparam longint unsigned T2   = ((T1 * TH2) >> 30) / 64'd20;
		localparam longint unsigned T3   = ((T2 * TH2) >> 30) / 64'd42;
		localparam longint unsigned T4   = ((T3 * TH2) >> 30) / 64'd72;
		localparam longint unsigned T5   = ((T4 * TH2) >> 30) / 64'd110;
		localparam longint unsigned T6   = ((T5 * TH2) >> 30) / 64'd156;
		localparam longint          SUM  = longint'(TH) - longint'(T1) + longint'(T2)
			- longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6);
		localparam longint unsigned SINE = (SUM < 0) ? 64'd0 : 64'(SUM);
		localparam longint unsigned NUM  = (SINE * S_U) << 15;
		localparam longint unsigned DEN  = (M == 0) ? 64'd1 : PI_Q30 * M;
		localparam longint unsigned MAG  = (NUM + DEN / 2) / DEN;
		localparam coef_t           COEF = (M == 0) ? coef_t'(32768)
			: NEG ? coef_t'(-longint'(MAG)) : coef_t'(MAG);
		assign coef_rom[g] = COEF;
	end

	// position and emit decision
	logic [POS_W:0]    pos_half;
	logic [CEN_W-1:0]  centre;
	logic              emit_ok;
	logic              last_out;

	assign pos_half = (POS_W+1)'(pos_q) + HALF;
	assign centre   = pos_half[POS_W:F];

	always_comb begin
		if (final_q)
			emit_ok = pos_q < {seen_q, {F{1'b0}}};
		else
			emit_ok = (K_W'(centre) + K_W'(TAP_REACH + 1)) <= K_W'(seen_q);
	end
	assign last_out = !emit_ok || (cnt_q == MAX_RESULTS);

	// tap issue: sample index, distance and ring address
	logic signed [K_W-1:0]   k;
	logic                    k_use;
	logic signed [K_W+F-1:0] diff;
	logic [K_W+F-1:0]        dabs;
	logic signed [K_W-1:0]   bk;
	logic [RA:0]             lp;
	logic [RA:0]             bo;
	logic [RA:0]             addr;

	always_comb begin
		k     = $signed(K_W'(centre)) - $signed(K_W'(TAP_REACH)) + $signed(K_W'(tap_q));
		k_use = !k[K_W-1] && (k < $signed(K_W'(seen_q)))
			&& ((k + $signed(K_W'(HISTORY_DEPTH))) >= $signed(K_W'(seen_q)));
		diff  = $signed((K_W+F)'(pos_q)) - $signed({k, {F{1'b0}}});
		dabs  = diff[K_W+F-1] ? (K_W+F)'(-diff) : (K_W+F)'(diff);
		bk    = $signed(K_W'(seen_q)) - $signed(K_W'(1)) - k;
		lp    = (RA+1)'(last_ptr_q);
		bo    = bk[RA:0];
		addr  = (lp >= bo) ? (lp - bo) : (lp + (RA+1)'(HISTORY_DEPTH) - bo);
	end

	// tap pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              use_s1, use_s2, use_s3;
	logic [D_W-1:0]    d_s1;
	logic [RA-1:0]     addr_s1;
	logic [ROM_AW-1:0] m_s2;
	sample_t           smp_s2, smp_s3;
	coef_t             coef_s3;
	logic signed [PROD_W-1:0] prod_s4;
	logic [D_W+SW:0]   m_full;
	logic              issue;
	logic              pipe_busy;

	assign issue     = state_q == ST_TAPS;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign m_full    = (D_W+SW+1)'(d_s1) * (D_W+SW+1)'(COEF_STEPS_PER_UNIT)
		+ (D_W+SW+1)'(HALF);

	always_ff @(posedge clk) begin
		use_s1  <= k_use;
		d_s1    <= dabs[D_W-1:0];
		addr_s1 <= addr[RA-1:0];
		use_s2  <= use_s1;
		m_s2    <= m_full[F +: ROM_AW];
		smp_s2  <= ring_q[addr_s1];
		use_s3  <= use_s2;
		coef_s3 <= coef_rom[m_s2];
		smp_s3  <= smp_s2;
		prod_s4 <= use_s3 ? PROD_W'(coef_s3) * PROD_W'(smp_s3) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// divide by 32768 toward zero, then saturate
	logic signed [ACC_W-1:0] acc_adj;
	logic signed [ACC_W-1:0] acc_div;
	sample_t                 sat;

	always_comb begin
		acc_adj = acc_q + (acc_q[ACC_W-1] ? $signed(ACC_W'(32767)) : $signed(ACC_W'(0)));
		acc_div = acc_adj >>> 15;
		if (acc_div > $signed(ACC_W'(32767)))
			sat = sample_t'(32767);
		else if (acc_div < -$signed(ACC_W'(32768)))
			sat = sample_t'(-32768);
		else
			sat = sample_t'(acc_div);
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (pop)
			ring_q[wr_ptr_q] <= head.mono;
		if (state_q == ST_DRAIN && !pipe_busy)
			res_q <= sat;
		if (state_q == ST_NEXT && out_free) begin
			out_sample <= res_q;
			run_end    <= last_out;
			sound_end  <= last_out && final_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seen_q     <= '0;
			pos_q      <= '0;
			wr_ptr_q   <= '0;
			last_ptr_q <= '0;
			final_q    <= 1'b0;
			cnt_q      <= '0;
			tap_q      <= '0;
			acc_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (v_s4)
				acc_q <= acc_q + ACC_W'(prod_s4);
			if (state_q == ST_NEXT && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						seen_q     <= seen_q + SEEN_W'(1);
						final_q    <= head.last
							|| ((SEEN_W+1)'(seen_q) + (SEEN_W+1)'(1) >= SEEN_LIMIT);
						last_ptr_q <= wr_ptr_q;
						wr_ptr_q   <= (wr_ptr_q == RA'(HISTORY_DEPTH - 1)) ? '0
							: wr_ptr_q + RA'(1);
						cnt_q      <= '0;
						state_q    <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (emit_ok) begin
						tap_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_TAPS;
					end else begin
						if (final_q) begin
							seen_q   <= '0;
							pos_q    <= '0;
							wr_ptr_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TAPS: begin
					tap_q <= tap_q + TC_W'(1);
					if (tap_q == TC_W'(TAPS - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						pos_q   <= pos_q + POS_W'(step);
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					// decide run end against the advanced position, then hand off
					if (out_free) begin
						if (last_out) begin
							if (final_q) begin
								seen_q   <= '0;
								pos_q    <= '0;
								wr_ptr_q <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							tap_q   <= '0;
							acc_q   <= '0;
							state_q <= ST_TAPS;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sinc_sample_rate_converter_top.sv =====
// Top level of the 9-tap sinc resampler: config registers, front end, queue, back end.
// Depends on ssrc_pkg, ssrc_front, ssrc_queue, ssrc_back.
//
// Each input frame is folded to mono (or reduced to its left sample when stereo mode is
// off) and queued; the back end stores it in the history and emits the outputs whose
// taps are now available (the remaining ones on the final frame), at most MAX_RESULTS
// per frame. Each output issues its taps on the single shared multiply-accumulate,
// waits for the tap pipeline to drain, and a control state then hands it to the output
// register. Two frames can wait in the queue while the back end works, and a finished
// output waits in the output register.
module sinc_sample_rate_converter_top #(
	parameter int unsigned TAP_REACH           = 4,
	parameter int unsigned HISTORY_DEPTH       = 16,
	parameter int unsigned PHASE_FRAC_BITS     = 16,
	parameter int unsigned COEF_STEPS_PER_UNIT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [ssrc_pkg::STEP_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ssrc_pkg::sample_t            left_sample,
	input  ssrc_pkg::sample_t            right_sample,
	input  logic                         final_frame,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssrc_pkg::sample_t            out_sample,
	output logic                         run_end,
	output logic                         sound_end
);
	import ssrc_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              stereo_q;
	logic [STEP_W-1:0] step_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			stereo_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PHASE_STEP:  step_q   <= cfg_data;
				REG_STEREO_MODE: stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (step_q < STEP_MIN)
			step_clamped = STEP_MIN;
		else if (step_q > STEP_MAX)
			step_clamped = STEP_MAX;
		else
			step_clamped = step_q;
	end

	ssrc_qstat_t q_stat;
	ssrc_job_t   push_job;
	ssrc_job_t   head;
	logic        push;
	logic        pop;

	ssrc_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.final_frame  (final_frame),
		.stereo_mode  (stereo_q),
		.q_stat       (q_stat),
		.push         (push),
		.job          (push_job)
	);

	ssrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	ssrc_back #(
		.TAP_REACH           (TAP_REACH),
		.HISTORY_DEPTH       (HISTORY_DEPTH),
		.PHASE_FRAC_BITS     (PHASE_FRAC_BITS),
		.COEF_STEPS_PER_UNIT (COEF_STEPS_PER_UNIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step_clamped),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.run_end    (run_end),
		.sound_end  (sound_end)
	);

	a_sound_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sound_end |-> run_end)
		else $error("sound end without run end");

	a_queue_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

// ===== dv/sinc_sample_rate_converter_top_test.sv =====
// Self-checking test of the 9-tap sinc resampler: directed, back-pressure, pause, random.
// Depends on ssrc_pkg and sinc_sample_rate_converter_top; outputs checked against
// an in-bench resampler model.
`timescale 1ns / 1ps

module sinc_sample_rate_converter_top_test;
	import ssrc_pkg::*;

	localparam int REACH = 4;
	localparam int DEPTH = 16;
	localparam int FRAC = 16;
	localparam longint unsigned STEPS = 256;
	localparam longint unsigned PI_FIX = 64'd3373259426;

	typedef struct {
		sample_t value;
		logic    run_last;
		logic    sound_last;
	} resampled_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = REG_PHASE_STEP;
	logic [STEP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t left_sample = '0;
	sample_t right_sample = '0;
	logic final_frame = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	sample_t out_sample;
	logic run_end;
	logic sound_end;

	// model state
	sample_t mono_hist[DEPTH];
	longint unsigned frames_in_sound;
	longint unsigned next_pos;
	logic [STEP_W-1:0] step_cfg;
	logic stereo_cfg;

	resampled_t pending_outputs[$];
	int errors = 0;
	int frames_sent = 0;
	int outputs_checked = 0;
	int sounds_sent = 0;
	int hold_requests = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;

	sinc_sample_rate_converter_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_sample(left_sample), .right_sample(right_sample), .final_frame(final_frame),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_sample(out_sample), .run_end(run_end), .sound_end(sound_end)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned sine_fix(longint unsigned r);
		longint unsigned th;
		longint unsigned th2;
		longint unsigned term;
		longint acc;
		th = (PI_FIX * r) / STEPS;
		th2 = (th * th) >> 30;
		term = th;
		acc = longint'(th);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		return (acc < 0) ? 0 : longint'(acc);
	endfunction

	function automatic longint sinc_weight(longint unsigned m);
		longint unsigned r;
		longint unsigned num;
		longint unsigned den;
		longint mag;
		if (m == 0)
			return 32768;
		r = m % STEPS;
		if (r * 2 > STEPS)
			r = STEPS - r;
		num = (sine_fix(r) * STEPS) << 15;
		den = PI_FIX * m;
		mag = longint'((num + den / 2) / den);
		return (((m / STEPS) % 2) == 1) ? -mag : mag;
	endfunction

	function automatic sample_t interpolate(longint unsigned pos, longint unsigned centre);
		longint acc;
		longint k;
		longint unsigned kp;
		longint unsigned d;
		longint unsigned m;
		acc = 0;
		for (int j = -REACH; j <= REACH; j++) begin
			k = longint'(centre) + j;
			if (k < 0 || longint'(frames_in_sound) <= k || k + DEPTH < longint'(frames_in_sound))
				continue;
			kp = longint'(k) << FRAC;
			d = (pos >= kp) ? pos - kp : kp - pos;
			m = (d * STEPS + (1 << (FRAC - 1))) >> FRAC;
			acc += sinc_weight(m) * longint'(mono_hist[k % DEPTH]);
		end
		acc = acc / 32768;
		if (acc > 32767)
			acc = 32767;
		if (acc < -32768)
			acc = -32768;
		return sample_t'(acc);
	endfunction

	// advance the model by one frame and queue what it should produce
	task automatic predict_frame(sample_t l, sample_t r, logic fin);
		int mono;
		bit last;
		int count;
		longint unsigned step;
		longint unsigned centre;
		resampled_t res;
		mono = stereo_cfg ? (int'(l) + int'(r)) / 2 : int'(l);
		mono_hist[frames_in_sound % DEPTH] = sample_t'(mono);
		frames_in_sound++;
		last = fin || frames_in_sound >= 64'hFFFF0000;
		step = 64'(step_cfg);
		if (step < 16384)
			step = 16384;
		if (step > 524288)
			step = 524288;
		count = 0;
		while (count < 32) begin
			centre = (next_pos + (1 << (FRAC - 1))) >> FRAC;
			if (last) begin
				if (next_pos >= (frames_in_sound << FRAC))
					break;
			end else if (centre + REACH > frames_in_sound - 1) begin
				break;
			end
			res.value = interpolate(next_pos, centre);
			res.run_last = 1'b0;
			res.sound_last = 1'b0;
			pending_outputs.push_back(res);
			next_pos = (next_pos + step) & 48'hFFFF_FFFF_FFFF;
			count++;
		end
		if (count > 0) begin
			pending_outputs[$].run_last = 1'b1;
			pending_outputs[$].sound_last = last;
		end
		if (last) begin
			foreach (mono_hist[i])
				mono_hist[i] = '0;
			frames_in_sound = 0;
			next_pos = 0;
			sounds_sent++;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on output %0d: %s got %0d expected %0d", outputs_checked, what, got,
			want);
		errors++;
	endtask

	// one request on the input channel; valid stays high unless a gap is drawn
	task automatic send_frame(sample_t l, sample_t r, logic fin);
		predict_frame(l, r, fin);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		left_sample = l;
		right_sample = r;
		final_frame = fin;
		do
			@(posedge clk);
		while (in_stall);
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [STEP_W-1:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_PHASE_STEP)
			step_cfg = val;
		else
			stereo_cfg = val[0];
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic send_sound(int len);
		for (int i = 0; i < len; i++)
			send_frame(rand_sample(), rand_sample(), i == len - 1);
	endtask

	task automatic test_directed();
		// impulse-like extremes in mono at unity step
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		send_frame(16'sh0000, 16'shFFFF, 1'b0);
		send_frame(16'sh0001, 16'sh5555, 1'b0);
		send_frame(16'shFFFF, 16'shAAAA, 1'b0);
		send_frame(16'sh7FFF, 16'sh0000, 1'b0);
		send_frame(16'sh7FFF, 16'sh0000, 1'b1);
		// single-frame sound
		send_frame(16'sh1234, 16'sh0000, 1'b1);
		wait_idle();
		// stereo averaging, truncation toward zero
		write_reg(REG_STEREO_MODE, 20'd1);
		send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_frame(16'sh8000, 16'sh8000, 1'b0);
		send_frame(16'shFFFF, 16'sh0000, 1'b0);
		send_frame(16'shFFFD, 16'sh0000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b1);
		wait_idle();
		// widest step: final frame finds nothing left to emit
		write_reg(REG_STEREO_MODE, 20'd0);
		write_reg(REG_PHASE_STEP, 20'd524288);
		for (int i = 0; i < 6; i++)
			send_frame(16'sh4000, 16'sh0000, i == 5);
		wait_idle();
		// out-of-range steps get clamped
		write_reg(REG_PHASE_STEP, 20'd0);
		send_sound(4);
		wait_idle();
		write_reg(REG_PHASE_STEP, 20'hFFFFF);
		send_sound(4);
		wait_idle();
	endtask

	task automatic test_random_sounds(int target);
		int sel;
		int len;
		while (frames_sent < target) begin
			sel = $urandom_range(0, 3);
			write_reg(REG_PHASE_STEP, sel == 0 ? 20'd16384 : sel == 1 ? 20'd524288 :
				20'($urandom_range(16384, 524288)));
			write_reg(REG_STEREO_MODE, 20'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 3)) begin
				len = $urandom_range(1, 30);
				if (len > target - frames_sent)
					len = target - frames_sent;
				if (len > 0)
					send_sound(len);
			end
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_PHASE_STEP, 20'd16384);
		hold_requests++;
		send_sound(20);
		wait_idle();
	endtask

	task automatic test_mid_sound_pause();
		write_reg(REG_PHASE_STEP, 20'd40000);
		for (int i = 0; i < 10; i++)
			send_frame(rand_sample(), rand_sample(), 1'b0);
		// drain everything, then pick the sound back up
		wait_idle();
		for (int i = 0; i < 10; i++)
			send_frame(rand_sample(), rand_sample(), i == 9);
		wait_idle();
	endtask

	always @(negedge clk) begin : out_stall_gen
		int burst;
		int hold_seen;
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_cycles = 400;
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst > 0) begin
			out_stall <= 1'b1;
			burst--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			burst = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_outputs
		resampled_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected out_sample", out_sample, 0);
			end else begin
				want = pending_outputs.pop_front();
				if (out_sample !== want.value)
					report_mismatch("out_sample", out_sample, want.value);
				if (run_end !== want.run_last)
					report_mismatch("run_end", run_end, want.run_last);
				if (sound_end !== want.sound_last)
					report_mismatch("sound_end", sound_end, want.sound_last);
			end
			outputs_checked++;
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		foreach (mono_hist[i])
			mono_hist[i] = '0;
		frames_in_sound = 0;
		next_pos = 0;
		step_cfg = STEP_W'(65536);
		stereo_cfg = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_mid_sound_pause();
		test_random_sounds(300);
		quiet = 1'b1;
		test_random_sounds(380);
		repeat (60) @(negedge clk);
		$display("%0d frames in %0d sounds, %0d resampled outputs checked", frames_sent,
			sounds_sent, outputs_checked);
		if (errors == 0 && pending_outputs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ssrc_pkg.sv
rtl/ssrc_front.sv
rtl/ssrc_queue.sv
rtl/ssrc_back.sv
rtl/sinc_sample_rate_converter_top.sv
dv/sinc_sample_rate_converter_top_test.sv
